// ----- design/lbcm_pkg.sv -----
// letterbox coordinate mapper: shared widths, constants and types
// no dependencies; imported by every module of the block
`default_nettype none

package lbcm_pkg;

	localparam int CFG_W     = 14;
	localparam int CFG_IDX_W = 1;
	localparam int IN_W      = 15;
	localparam int OUT_W     = 23;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WINDOW_WIDTH_RESET  = 14'd640;
	localparam logic [CFG_W-1:0] WINDOW_HEIGHT_RESET = 14'd480;

	localparam logic [CFG_W-1:0] FRAME_WIDTH  = 14'd320;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT = 14'd200;

	localparam logic OP_TO_WINDOW = 1'b0;
	localparam logic OP_TO_FRAME  = 1'b1;

	// floor(v / 3) = (v * DIV3_MUL) >> DIV3_SHIFT for v below 2**17
	localparam logic [15:0] DIV3_MUL   = 16'd43691;
	localparam int          DIV3_SHIFT = 17;

	// divider: numerator and quotient magnitude, bits resolved per stage
	localparam int NUM_W      = 28;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = NUM_W / DIV_STEPS;

	localparam int SUM_W = NUM_W + 2;

	localparam int GEOM_LAT = 4;
	localparam int AXIS_LAT = 3 + DIV_STAGES + 2;
	localparam int PIPE_LAT = GEOM_LAT + AXIS_LAT;

	localparam logic signed [OUT_W-1:0] OUT_HI = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_LO = {1'b1, {(OUT_W-1){1'b0}}};

	typedef struct packed {
		logic             bad;
		logic [CFG_W-1:0] vw;
		logic [CFG_W-1:0] vh;
		logic [CFG_W-1:0] left;
		logic [CFG_W-1:0] top;
	} geom_t;

	typedef struct packed {
		logic             neg;
		logic             bad;
		logic [CFG_W-1:0] base;
	} div_tag_t;

	typedef struct packed {
		logic                   op;
		logic signed [IN_W-1:0] x;
		logic signed [IN_W-1:0] y;
	} item_t;

endpackage

`default_nettype wire

// ----- design/lbcm_geom.sv -----
// viewport geometry pipeline: window size in, 4:3 viewport size and offsets out
// four register stages; uses lbcm_pkg
`default_nettype none

module lbcm_geom (
	input  logic                       clk,
	input  logic [lbcm_pkg::CFG_W-1:0] window_width,
	input  logic [lbcm_pkg::CFG_W-1:0] window_height,
	output lbcm_pkg::geom_t            geom
);
	import lbcm_pkg::*;

	logic [CFG_W-1:0] w_s1, h_s1;

	logic             wide_s2, bad_s2;
	logic [CFG_W:0]   hq_s2;
	logic [CFG_W-1:0] wq_s2, w_s2, h_s2;

	logic             bad_s3;
	logic [CFG_W-1:0] vw_s3, vh_s3, w_s3, h_s3;

	geom_t geom_s4;

	logic [CFG_W+1:0] w3, h4;
	logic [31:0]      hq_prod;
	logic [CFG_W-1:0] vw_sel, vh_sel, h_gap;

	assign w3      = {2'b00, w_s1} + {1'b0, w_s1, 1'b0};
	assign h4      = {h_s1, 2'b00};
	assign hq_prod = {16'd0, h4} * {16'd0, DIV3_MUL};

	assign vw_sel = wide_s2 ? hq_s2[CFG_W-1:0] : w_s2;
	assign vh_sel = wide_s2 ? h_s2 : wq_s2;
	assign h_gap  = h_s3 - vh_s3;

	always_ff @(posedge clk) begin
		w_s1 <= window_width;
		h_s1 <= window_height;

		wide_s2 <= w3 > h4;
		bad_s2  <= (w_s1 == '0) || (h_s1 == '0);
		hq_s2   <= hq_prod[DIV3_SHIFT +: (CFG_W+1)];
		wq_s2   <= w3[CFG_W+1:2];
		w_s2    <= w_s1;
		h_s2    <= h_s1;

		bad_s3 <= bad_s2;
		vw_s3  <= (vw_sel == '0) ? CFG_W'(1) : vw_sel;
		vh_s3  <= (vh_sel == '0) ? CFG_W'(1) : vh_sel;
		w_s3   <= w_s2;
		h_s3   <= h_s2;

		geom_s4.bad  <= bad_s3;
		geom_s4.vw   <= vw_s3;
		geom_s4.vh   <= vh_s3;
		geom_s4.left <= (w_s3 - vw_s3) >> 1;
		geom_s4.top  <= h_gap - (h_gap >> 1);
	end

	assign geom = geom_s4;

endmodule

`default_nettype wire

// ----- design/lbcm_div.sv -----
// pipelined unsigned restoring divider, DIV_STEPS quotient bits per stage
// carries a side tag along with each item; uses lbcm_pkg
`default_nettype none

module lbcm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [lbcm_pkg::NUM_W-1:0] num,
	input  logic [lbcm_pkg::CFG_W-1:0] den,
	input  lbcm_pkg::div_tag_t         in_tag,
	output logic                       out_valid,
	output logic [lbcm_pkg::NUM_W-1:0] quot,
	output lbcm_pkg::div_tag_t         out_tag
);
	import lbcm_pkg::*;

	function automatic logic [CFG_W+NUM_W-1:0] div_steps(
		input logic [CFG_W-1:0] rem,
		input logic [NUM_W-1:0] nq,
		input logic [CFG_W-1:0] dv
	);
		logic [CFG_W:0]   t;
		logic [CFG_W-1:0] r;
		logic [NUM_W-1:0] v;
		r = rem;
		v = nq;
		for (int k = 0; k < DIV_STEPS; k++) begin
			t = {r, v[NUM_W-1]};
			v = {v[NUM_W-2:0], 1'b0};
			if (t >= {1'b0, dv}) begin
				t    = t - {1'b0, dv};
				v[0] = 1'b1;
			end
			r = t[CFG_W-1:0];
		end
		return {r, v};
	endfunction

	logic             valid_s [DIV_STAGES];
	logic [CFG_W-1:0] rem_s   [DIV_STAGES];
	logic [NUM_W-1:0] nq_s    [DIV_STAGES];
	logic [CFG_W-1:0] den_s   [DIV_STAGES];
	div_tag_t         tag_s   [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [CFG_W+NUM_W-1:0] step;
		logic                   valid_in;
		logic [CFG_W-1:0]       den_in;
		div_tag_t               tag_in;

		if (i == 0) begin : g_first
			assign step     = div_steps({CFG_W{1'b0}}, num, den);
			assign valid_in = in_valid;
			assign den_in   = den;
			assign tag_in   = in_tag;
		end else begin : g_next
			assign step     = div_steps(rem_s[i-1], nq_s[i-1], den_s[i-1]);
			assign valid_in = valid_s[i-1];
			assign den_in   = den_s[i-1];
			assign tag_in   = tag_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else begin
				valid_s[i] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= step[CFG_W+NUM_W-1:NUM_W];
			nq_s[i]  <= step[NUM_W-1:0];
			den_s[i] <= den_in;
			tag_s[i] <= tag_in;
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign quot      = nq_s[DIV_STAGES-1];
	assign out_tag   = tag_s[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- design/lbcm_axis.sv -----
// one coordinate axis: operand setup, scale, divide, sign, offset and saturate
// instantiates lbcm_div; uses lbcm_pkg
`default_nettype none

module lbcm_axis (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_op,
	input  logic signed [lbcm_pkg::IN_W-1:0]  coord,
	input  logic [lbcm_pkg::CFG_W-1:0]        size,
	input  logic [lbcm_pkg::CFG_W-1:0]        offset,
	input  logic [lbcm_pkg::CFG_W-1:0]        frame_size,
	input  logic                              bad,
	output logic                              out_valid,
	output logic                              out_ok,
	output logic signed [lbcm_pkg::OUT_W-1:0] result
);
	import lbcm_pkg::*;

	localparam int PROD_W = IN_W + 1 + CFG_W;

	logic             valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [IN_W:0]    diff_s1;
	logic [CFG_W-1:0] mul_s1, dvs_s1, base_s1, mul_s2, dvs_s2, base_s2, dvs_s3;
	logic             bad_s1, bad_s2, bad_s4, ok_s5;
	logic             neg_s2;
	logic [IN_W:0]    mag_s2;
	logic [NUM_W-1:0] num_s3;
	div_tag_t         tag_s3;
	logic signed [SUM_W-1:0] sum_s4;
	logic signed [OUT_W-1:0] result_s5;

	logic [IN_W:0]    coord_ext, offset_ext;
	logic [PROD_W-1:0] prod;
	logic             q_valid;
	logic [NUM_W-1:0] quot;
	div_tag_t         q_tag;
	logic [NUM_W:0]   q_signed;

	localparam logic signed [SUM_W-1:0] SUM_HI = {{(SUM_W-OUT_W){1'b0}}, OUT_HI};
	localparam logic signed [SUM_W-1:0] SUM_LO = {{(SUM_W-OUT_W){1'b1}}, OUT_LO};

	assign coord_ext  = {coord[IN_W-1], coord};
	assign offset_ext = {{(IN_W+1-CFG_W){1'b0}}, offset};
	assign prod       = {{CFG_W{1'b0}}, mag_s2} * {{(IN_W+1){1'b0}}, mul_s2};
	assign q_signed   = q_tag.neg ? -{1'b0, quot} : {1'b0, quot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= q_valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		// operand setup per direction
		diff_s1 <= (in_op == OP_TO_FRAME) ? coord_ext - offset_ext : coord_ext;
		mul_s1  <= (in_op == OP_TO_FRAME) ? frame_size : size;
		dvs_s1  <= (in_op == OP_TO_FRAME) ? size : frame_size;
		base_s1 <= (in_op == OP_TO_WINDOW) ? offset : '0;
		bad_s1  <= bad;

		neg_s2  <= diff_s1[IN_W];
		mag_s2  <= diff_s1[IN_W] ? -diff_s1 : diff_s1;
		mul_s2  <= mul_s1;
		dvs_s2  <= dvs_s1;
		base_s2 <= base_s1;
		bad_s2  <= bad_s1;

		num_s3      <= prod[NUM_W-1:0];
		dvs_s3      <= dvs_s2;
		tag_s3.neg  <= neg_s2;
		tag_s3.bad  <= bad_s2;
		tag_s3.base <= base_s2;

		sum_s4 <= {q_signed[NUM_W], q_signed} + {{(SUM_W-CFG_W){1'b0}}, q_tag.base};
		bad_s4 <= q_tag.bad;

		ok_s5 <= !bad_s4;
		priority if (bad_s4) begin
			result_s5 <= '0;
		end else if (sum_s4 > SUM_HI) begin
			result_s5 <= OUT_HI;
		end else if (sum_s4 < SUM_LO) begin
			result_s5 <= OUT_LO;
		end else begin
			result_s5 <= sum_s4[OUT_W-1:0];
		end
	end

	lbcm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.num      (num_s3),
		.den      (dvs_s3),
		.in_tag   (tag_s3),
		.out_valid(q_valid),
		.quot     (quot),
		.out_tag  (q_tag)
	);

	assign out_valid = valid_s5;
	assign out_ok    = ok_s5;
	assign result    = result_s5;

endmodule

`default_nettype wire

// ----- design/letterbox_coordinate_mapper.sv -----
// letterbox coordinate mapper top level: config registers, item delay line, two axes
// instantiates lbcm_geom and lbcm_axis; uses lbcm_pkg
//
// usage
//   config: cfg_we writes cfg_wdata into register cfg_idx (0 window_width,
//   1 window_height) at the clock edge, no wait; write only while no item
//   is in flight. reset values are 640 and 480.
//   input: an item (op, in_x, in_y) is taken at each edge where start is
//   high and busy is low. busy is always low: one item per clock.
//   output: done marks ok, out_x, out_y for exactly one cycle, in input
//   order. the receiver cannot stall.
//   latency is set by 4 geometry stages, 3 operand stages, a 14-stage
//   divider resolving 2 quotient bits per stage, and 2 output stages.
//   throughput: one item per cycle.
//   ok is low with zero coordinates when a window side is zero.
//   reset: arst_n clears all valid bits and loads the window defaults;
//   items in flight are dropped.
`default_nettype none

module letterbox_coordinate_mapper #(
	parameter logic [lbcm_pkg::CFG_W-1:0] FRAME_WIDTH  = lbcm_pkg::FRAME_WIDTH,
	parameter logic [lbcm_pkg::CFG_W-1:0] FRAME_HEIGHT = lbcm_pkg::FRAME_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic signed [lbcm_pkg::IN_W-1:0]  in_x,
	input  logic signed [lbcm_pkg::IN_W-1:0]  in_y,
	output logic                              done,
	output logic                              ok,
	output logic signed [lbcm_pkg::OUT_W-1:0] out_x,
	output logic signed [lbcm_pkg::OUT_W-1:0] out_y,
	input  logic                              cfg_we,
	input  logic [lbcm_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [lbcm_pkg::CFG_W-1:0]        cfg_wdata
);
	import lbcm_pkg::*;

	logic [CFG_W-1:0] window_width_q, window_height_q;

	logic  valid_s [GEOM_LAT];
	item_t item_s  [GEOM_LAT];

	geom_t geom;
	logic  y_valid, y_ok;
	item_t item_in;

	assign busy    = 1'b0;
	assign item_in = '{op: op, x: in_x, y: in_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q  <= WINDOW_WIDTH_RESET;
			window_height_q <= WINDOW_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WINDOW_WIDTH:  window_width_q  <= cfg_wdata;
				REG_WINDOW_HEIGHT: window_height_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GEOM_LAT; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else begin
			valid_s[0] <= start && !busy;
			for (int i = 1; i < GEOM_LAT; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		item_s[0] <= item_in;
		for (int i = 1; i < GEOM_LAT; i++) begin
			item_s[i] <= item_s[i-1];
		end
	end

	lbcm_geom u_geom (
		.clk          (clk),
		.window_width (window_width_q),
		.window_height(window_height_q),
		.geom         (geom)
	);

	lbcm_axis u_axis_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s[GEOM_LAT-1]),
		.in_op     (item_s[GEOM_LAT-1].op),
		.coord     (item_s[GEOM_LAT-1].x),
		.size      (geom.vw),
		.offset    (geom.left),
		.frame_size(FRAME_WIDTH),
		.bad       (geom.bad),
		.out_valid (done),
		.out_ok    (ok),
		.result    (out_x)
	);

	lbcm_axis u_axis_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s[GEOM_LAT-1]),
		.in_op     (item_s[GEOM_LAT-1].op),
		.coord     (item_s[GEOM_LAT-1].y),
		.size      (geom.vh),
		.offset    (geom.top),
		.frame_size(FRAME_HEIGHT),
		.bad       (geom.bad),
		.out_valid (y_valid),
		.out_ok    (y_ok),
		.result    (out_y)
	);

	a_axes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (done == y_valid) && (!done || (ok == y_ok)))
		else $error("x and y axes out of step");

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("item result missing at fixed latency");

	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (out_x == '0) && (out_y == '0))
		else $error("invalid window result not zero");

endmodule

`default_nettype wire

// ----- dv/letterbox_coordinate_mapper_test.sv -----
// testbench for letterbox_coordinate_mapper: directed corners, then random windows and points
// holds its own viewport predictor and scoreboard; needs lbcm_pkg and the block only
`timescale 1ns / 100ps

module letterbox_coordinate_mapper_test;
	import lbcm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	class point_checker;
		typedef struct {
			logic                    ok;
			logic signed [OUT_W-1:0] x;
			logic signed [OUT_W-1:0] y;
		} mapped_t;

		mapped_t          pending[$];
		int               mismatches;
		logic [CFG_W-1:0] win_w;
		logic [CFG_W-1:0] win_h;

		function new();
			win_w      = WINDOW_WIDTH_RESET;
			win_h      = WINDOW_HEIGHT_RESET;
			mismatches = 0;
		endfunction

		function void set_window(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
			win_w = w;
			win_h = h;
		endfunction

		function logic signed [OUT_W-1:0] clamp_out(longint v);
			if (v > longint'(OUT_HI))
				return OUT_HI;
			if (v < longint'(OUT_LO))
				return OUT_LO;
			return v[OUT_W-1:0];
		endfunction

		function void note_point(logic op_in, logic signed [IN_W-1:0] x,
			logic signed [IN_W-1:0] y);
			longint  w, h, vw, vh, left, bottom, top, px, py, fw, fh, rx, ry;
			mapped_t m;
			w  = win_w;
			h  = win_h;
			px = x;
			py = y;
			fw = FRAME_WIDTH;
			fh = FRAME_HEIGHT;
			if (w < 1 || h < 1) begin
				m.ok = 1'b0;
				m.x  = '0;
				m.y  = '0;
			end else begin
				if (w * 3 > h * 4) begin
					vh = h;
					vw = h * 4 / 3;
				end else begin
					vw = w;
					vh = w * 3 / 4;
				end
				if (vw < 1)
					vw = 1;
				if (vh < 1)
					vh = 1;
				left   = (w - vw) / 2;
				bottom = (h - vh) / 2;
				top    = h - bottom - vh;
				if (op_in == OP_TO_WINDOW) begin
					rx = left + px * vw / fw;
					ry = top + py * vh / fh;
				end else begin
					rx = (px - left) * fw / vw;
					ry = (py - top) * fh / vh;
				end
				m.ok = 1'b1;
				m.x  = clamp_out(rx);
				m.y  = clamp_out(ry);
			end
			pending.push_back(m);
		endfunction

		function void check_point(logic ok_out, logic signed [OUT_W-1:0] x,
			logic signed [OUT_W-1:0] y);
			mapped_t m;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: ok %0b x %0d y %0d", ok_out, x, y);
				return;
			end
			m = pending.pop_front();
			if (ok_out !== m.ok || x !== m.x || y !== m.y) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected ok %0b x %0d y %0d, got ok %0b x %0d y %0d",
						m.ok, m.x, m.y, ok_out, x, y);
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    op;
	logic signed [IN_W-1:0]  in_x;
	logic signed [IN_W-1:0]  in_y;
	logic                    done;
	logic                    ok;
	logic signed [OUT_W-1:0] out_x;
	logic signed [OUT_W-1:0] out_y;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_idx;
	logic [CFG_W-1:0]        cfg_wdata;
	int                      cycles = 0;

	point_checker board = new();

	letterbox_coordinate_mapper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.in_x      (in_x),
		.in_y      (in_y),
		.done      (done),
		.ok        (ok),
		.out_x     (out_x),
		.out_y     (out_y),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			board.note_point(op, in_x, in_y);
		if (arst_n && done)
			board.check_point(ok, out_x, out_y);
	end

	task automatic send_point(logic op_in, logic signed [IN_W-1:0] x,
		logic signed [IN_W-1:0] y, bit allow_gap);
		start <= 1'b1;
		op    <= op_in;
		in_x  <= x;
		in_y  <= y;
		do
			@(posedge clk);
		while (busy);
		if (allow_gap && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_window(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_WINDOW_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_idx   <= REG_WINDOW_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_window(w, h);
	endtask

	function automatic logic [CFG_W-1:0] pick_side();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return '1;
			2, 3:    return CFG_W'($urandom_range(1, 8));
			4, 5, 6, 7, 8, 9:
				return CFG_W'($urandom_range(100, 2000));
			default: return CFG_W'($urandom_range(1, 16383));
		endcase
	endfunction

	function automatic logic signed [IN_W-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0:       return {1'b1, {(IN_W-1){1'b0}}};
			1:       return {1'b0, {(IN_W-1){1'b1}}};
			2:       return '0;
			3:       return IN_W'($urandom_range(0, 700));
			4:       return IN_W'(-int'($urandom_range(0, 700)));
			default: return IN_W'($urandom);
		endcase
	endfunction

	localparam logic signed [IN_W-1:0] XMIN = {1'b1, {(IN_W-1){1'b0}}};
	localparam logic signed [IN_W-1:0] XMAX = {1'b0, {(IN_W-1){1'b1}}};

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		op        <= OP_TO_WINDOW;
		in_x      <= '0;
		in_y      <= '0;
		cfg_we    <= 1'b0;
		cfg_idx   <= REG_WINDOW_WIDTH;
		cfg_wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window
		send_point(OP_TO_WINDOW, XMIN, XMAX, 1'b1);
		send_point(OP_TO_WINDOW, XMAX, XMIN, 1'b1);
		send_point(OP_TO_WINDOW, IN_W'(0), IN_W'(0), 1'b1);
		send_point(OP_TO_WINDOW, IN_W'(-1), IN_W'(1), 1'b1);
		send_point(OP_TO_FRAME, XMIN, XMAX, 1'b1);
		send_point(OP_TO_FRAME, XMAX, XMIN, 1'b1);
		send_point(OP_TO_FRAME, IN_W'(0), IN_W'(0), 1'b1);
		send_point(OP_TO_FRAME, IN_W'(-1), IN_W'(1), 1'b1);
		// one pixel wide viewport, saturates on the way back
		set_window(14'd1, 14'd16383);
		send_point(OP_TO_FRAME, XMAX, XMAX, 1'b1);
		send_point(OP_TO_FRAME, XMIN, XMIN, 1'b1);
		send_point(OP_TO_WINDOW, XMAX, XMIN, 1'b1);
		// zero sides
		set_window(14'd0, 14'd480);
		send_point(OP_TO_WINDOW, XMAX, XMAX, 1'b1);
		send_point(OP_TO_FRAME, XMIN, IN_W'(5), 1'b1);
		set_window(14'd640, 14'd0);
		send_point(OP_TO_FRAME, IN_W'(7), XMAX, 1'b1);
		set_window(14'd16383, 14'd1);
		send_point(OP_TO_FRAME, XMAX, IN_W'(0), 1'b1);
		send_point(OP_TO_WINDOW, XMIN, XMAX, 1'b1);
		set_window(14'd16383, 14'd16383);
		send_point(OP_TO_WINDOW, XMAX, XMAX, 1'b1);
		send_point(OP_TO_WINDOW, XMIN, XMIN, 1'b1);
		send_point(OP_TO_FRAME, XMAX, XMIN, 1'b1);
		send_point(OP_TO_FRAME, XMIN, XMAX, 1'b1);
		set_window(14'd1, 14'd1);
		send_point(OP_TO_WINDOW, XMAX, XMIN, 1'b1);
		send_point(OP_TO_FRAME, XMIN, XMAX, 1'b1);

		for (int phase = 0; phase < 10; phase++) begin
			set_window(pick_side(), pick_side());
			for (int n = 0; n < 105; n++) begin
				if (phase == 6 && n == 50)
					wait_drained();
				send_point(1'($urandom), pick_coord(), pick_coord(), phase != 4);
			end
		end

		wait_drained();
		repeat (PIPE_LAT + 4) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/lbcm_pkg.sv
design/lbcm_geom.sv
design/lbcm_div.sv
design/lbcm_axis.sv
design/letterbox_coordinate_mapper.sv
dv/letterbox_coordinate_mapper_test.sv
